### rtl/asort_pkg.sv
// Shared types for the ascending set sorter.
// Holds the controller state encoding and the command and status bundles
// that join the controller to the datapath. No dependencies.
package asort_pkg;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_LOAD,
    S_CAPT,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_first;
    logic capture;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic single;
    logic scan_done;
    logic out_free;
    logic final_out;
  } sts_t;

endpackage

### rtl/asort_dp.sv
// Datapath of the ascending set sorter: element memory, count, overflow
// flag, selection registers and the output register.
// Depends on asort_pkg for the command and status bundles.
module asort_dp #(
  parameter int MAX_ITEMS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  asort_pkg::cmd_t     cmd,
  output asort_pkg::sts_t     sts,
  input  logic signed [31:0]  value,
  input  logic                out_stall,
  output logic                out_valid,
  output logic signed [31:0]  value_res,
  output logic                last_res,
  output logic                overflow
);
  import asort_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic signed [31:0] mem [MAX_ITEMS];
  logic signed [31:0] rdata;
  logic signed [31:0] cur;
  logic [CW-1:0]      count;
  logic               ovf;
  logic [AW-1:0]      i;
  logic [AW-1:0]      j;
  logic [AW-1:0]      raddr;
  logic [CW-1:0]      i_inc;
  logic [CW-1:0]      j_inc;
  logic               swap;
  logic               has_room;

  assign i_inc    = CW'(i) + CW'(1);
  assign j_inc    = CW'(j) + CW'(1);
  assign swap     = rdata < cur;
  assign has_room = count < CW'(MAX_ITEMS);

  assign sts.single    = i_inc == count;
  assign sts.final_out = i_inc == count;
  assign sts.scan_done = j_inc == count;
  assign sts.out_free  = !out_valid || !out_stall;

  always_comb begin
    raddr = i;
    if (cmd.rd_first) begin
      raddr = '0;
    end else if (cmd.capture || cmd.emit) begin
      raddr = AW'(i_inc);
    end else if (cmd.scan) begin
      raddr = AW'(j_inc);
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (cmd.accept && has_room) begin
      mem[count[AW-1:0]] <= value;
    end else if (cmd.scan && swap) begin
      mem[j] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      i <= '0;
    end else if (cmd.emit) begin
      i <= AW'(i_inc);
    end
    if (cmd.capture) begin
      cur <= rdata;
      j   <= AW'(i_inc);
    end else if (cmd.scan) begin
      if (swap) begin
        cur <= rdata;
      end
      j <= AW'(j_inc);
    end
    if (cmd.emit) begin
      value_res <= cur;
      last_res  <= sts.final_out;
      overflow  <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (has_room) begin
          count <= count + CW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end else if (cmd.emit && sts.final_out) begin
        count <= '0;
        ovf   <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/asort_ctrl.sv
// Controller of the ascending set sorter: collects a set, then steps the
// datapath through one selection scan per result.
// Depends on asort_pkg for the state type and command/status bundles.
module asort_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             last,
  output logic             in_stall,
  input  asort_pkg::sts_t  sts,
  output asort_pkg::cmd_t  cmd
);
  import asort_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_COLLECT: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && last) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.rd_first = 1'b1;
        state_next   = S_CAPT;
      end
      S_CAPT: begin
        cmd.capture = 1'b1;
        state_next  = sts.single ? S_EMIT : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.final_out ? S_COLLECT : S_CAPT;
        end
      end
      default: begin
        state_next = S_COLLECT;
      end
    endcase
  end

endmodule

### rtl/ascending_set_sorter.sv
// Top level of the ascending set sorter.
// Instantiates asort_ctrl and asort_dp; types come from asort_pkg.
//
// Usage: the input channel (in_valid, in_stall, value, last) takes one
// signed element per transfer. A transfer with last high closes the set.
// Up to MAX_ITEMS elements are kept; further elements of the set are
// dropped and every result of that set then carries overflow high.
// The output channel (out_valid, out_stall, value_res, last_res, overflow)
// returns the stored elements in ascending signed order, last_res high on
// the final one.
// Throughput: while collecting, one element is taken per cycle.
// After the closing transfer the input stalls while a selection sort runs
// over the element memory, one compare per cycle on its single read port.
// A stalled receiver holds the result in the output register and the sort
// waits for it.
// Reset clears the element count, the overflow flag and out_valid; the
// block then accepts a new set.
module ascending_set_sorter #(
  parameter int MAX_ITEMS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  value,
  input  logic                last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  value_res,
  output logic                last_res,
  output logic                overflow
);
  import asort_pkg::*;

  cmd_t cmd;
  sts_t sts;

  asort_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  asort_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .value     (value),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .value_res (value_res),
    .last_res  (last_res),
    .overflow  (overflow)
  );

endmodule
